>>> src/fpmm_pkg.sv
// Package for the fp32 matrix multiply block: sizes, opcodes, register indices,
// unit control and status types and the size clamp. No dependencies.
package fpmm_pkg;

  localparam int MAX_DIM = 64;
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int CFG_W = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] OP_LOAD_LEFT = 2'd0;
  localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] OP_EMIT_ROW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_M = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_K = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_N = 2'd2;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  // control from sequencer to the arithmetic unit
  typedef struct packed {
    logic start_mul;
    logic start_add;
  } fpu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fpu_stat_t;

  // clamp register value to 1 .. MAX_DIM
  function automatic logic [IDX_W:0] eff_size(input logic [CFG_W-1:0] v);
    logic [IDX_W:0] r;
    if (v == '0) r = (IDX_W+1)'(1);
    else if (32'(v) > MAX_DIM) r = (IDX_W+1)'(MAX_DIM);
    else r = (IDX_W+1)'(v);
    return r;
  endfunction

endpackage

>>> src/fpmm_if.sv
// Valid/ready channel interface used on both sides of the block.
// Depends on nothing; payload width is set per instance.
interface fpmm_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> src/fpmm_fpu.sv
// Shared binary32 unit: a multiply or an add, with shared normalize and round
// states. Depends on fpmm_pkg.
module fpmm_fpu (
  input  logic                clk,
  input  logic                rst,
  input  fpmm_pkg::fpu_ctrl_t ctrl,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output fpmm_pkg::fpu_stat_t stat,
  output logic [31:0]         result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_SUM = 3'd3;
  localparam logic [2:0] S_NORM = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;

  localparam logic [31:0] QNAN_BITS_L = fpmm_pkg::QNAN_BITS;

  logic [2:0] state;
  logic       done;

  logic        sgn, sb_r, special;
  logic [31:0] spec_val;
  logic signed [11:0] ex;
  logic [57:0] sig;
  logic [57:0] xb;
  logic [23:0] ma_r, mb_r;
  logic [47:0] prod48;
  logic [9:0]  align_d;

  function automatic logic is_nan(input logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != '0;
  endfunction
  function automatic logic is_inf(input logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction
  function automatic logic is_zero(input logic [31:0] x);
    return x[30:0] == '0;
  endfunction
  function automatic logic [23:0] mant_of(input logic [31:0] x);
    return {x[30:23] != '0, x[22:0]};
  endfunction
  function automatic logic [7:0] exp_of(input logic [31:0] x);
    return (x[30:23] != '0) ? x[30:23] : 8'd1;
  endfunction

  // sticky right shift of a 58-bit value
  function automatic logic [57:0] shr_st(input logic [57:0] s, input logic [9:0] d);
    logic [57:0] m;
    logic [57:0] r;
    if (d >= 10'd58) begin
      r = {57'd0, s != '0};
    end else begin
      m = ~(58'h3FF_FFFF_FFFF_FFFF << d);
      r = (s >> d) | {57'd0, (s & m) != '0};
    end
    return r;
  endfunction

  // leading-one position of a 58-bit value
  function automatic logic [5:0] lead(input logic [57:0] s);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 58; i++) if (s[i]) p = 6'(i);
    return p;
  endfunction

  logic [5:0]  lp;
  logic [57:0] nsig;
  logic signed [11:0] nex;
  logic [9:0]  sub_d;
  logic [57:0] fsig;
  logic [31:0] low;
  logic [24:0] rsig;
  logic [24:0] rsig2;
  logic signed [11:0] rex;
  logic [31:0] packed_val;

  assign prod48 = ma_r * mb_r;

  // normalize so that the leading one sits at bit 55
  always_comb begin
    lp = lead(sig);
    if (lp > 6'd55) begin
      nsig = shr_st(sig, 10'(lp - 6'd55));
      nex = ex + 12'(lp - 6'd55);
    end else begin
      nsig = sig << (6'd55 - lp);
      nex = ex - 12'(6'd55 - lp);
    end
  end

  always_comb begin
    sub_d = (ex < 12'sd1) ? 10'(12'sd1 - ex) : '0;
    fsig = shr_st(sig, sub_d);
    rex = (ex < 12'sd1) ? 12'sd1 : ex;
    low = fsig[31:0];
    rsig = {1'b0, fsig[55:32]};
    if (low > 32'h8000_0000 || (low == 32'h8000_0000 && rsig[0])) rsig = rsig + 25'd1;
    rsig2 = rsig;
    if (rsig[24]) begin
      rsig2 = rsig >> 1;
      rex = rex + 12'sd1;
    end
    if (rex >= 12'sd255) packed_val = {sgn, 31'h7F80_0000};
    else packed_val = {sgn, rsig2[23] ? rex[7:0] : 8'd0, rsig2[22:0]};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (ctrl.start_mul) begin
            sgn <= a[31] ^ b[31];
            special <= 1'b1;
            if (is_nan(a) || is_nan(b)) spec_val <= QNAN_BITS_L;
            else if (is_inf(a) || is_inf(b))
              spec_val <= (is_zero(a) || is_zero(b)) ? QNAN_BITS_L
                          : {a[31] ^ b[31], 31'h7F80_0000};
            else if (is_zero(a) || is_zero(b)) spec_val <= {a[31] ^ b[31], 31'd0};
            else special <= 1'b0;
            ma_r <= mant_of(a);
            mb_r <= mant_of(b);
            ex <= 12'(exp_of(a)) + 12'(exp_of(b)) - 12'sd118;
            state <= S_MUL;
          end else if (ctrl.start_add) begin
            special <= 1'b1;
            if (is_nan(a) || is_nan(b)) spec_val <= QNAN_BITS_L;
            else if (is_inf(a)) spec_val <= (is_inf(b) && a[31] != b[31]) ? QNAN_BITS_L : a;
            else if (is_inf(b)) spec_val <= b;
            else if (is_zero(a) && is_zero(b)) spec_val <= {a[31] & b[31], 31'd0};
            else if (is_zero(a)) spec_val <= b;
            else if (is_zero(b)) spec_val <= a;
            else special <= 1'b0;
            // order operands by magnitude
            if (exp_of(b) > exp_of(a) || (exp_of(b) == exp_of(a) && mant_of(b) > mant_of(a)))
            begin
              sgn <= b[31]; sb_r <= a[31];
              ma_r <= mant_of(b); mb_r <= mant_of(a);
              ex <= 12'(exp_of(b));
              align_d <= 10'(exp_of(b) - exp_of(a));
            end else begin
              sgn <= a[31]; sb_r <= b[31];
              ma_r <= mant_of(a); mb_r <= mant_of(b);
              ex <= 12'(exp_of(a));
              align_d <= 10'(exp_of(a) - exp_of(b));
            end
            state <= S_ALIGN;
          end
        end
        S_MUL: begin
          sig <= {10'd0, prod48};
          state <= special ? S_ROUND : S_NORM;
        end
        S_ALIGN: begin
          xb <= shr_st({2'd0, mb_r, 32'd0}, align_d);
          sig <= {2'd0, ma_r, 32'd0};
          state <= S_SUM;
        end
        S_SUM: begin
          if (special) begin
            state <= S_ROUND;
          end else if (sgn == sb_r) begin
            sig <= sig + xb;
            state <= S_NORM;
          end else if (sig == xb) begin
            special <= 1'b1;
            spec_val <= '0;
            state <= S_ROUND;
          end else begin
            sig <= sig - xb;
            state <= S_NORM;
          end
        end
        S_NORM: begin
          sig <= nsig;
          ex <= nex;
          state <= S_ROUND;
        end
        S_ROUND: begin
          result <= special ? spec_val : packed_val;
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stat.busy = state != S_IDLE;
  assign stat.done = done;

`ifndef SYNTHESIS
  a_done_from_round: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_ROUND) else $error("done without round");
  a_no_start_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !(ctrl.start_mul && state == S_IDLE)) else $error("start");
  a_norm_lead: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && !special) |-> sig[57:56] == 2'b00) else $error("not normalized");
`endif

endmodule

>>> src/fp32_matrix_multiply.sv
// Top level of the fp32 matrix multiply block: stores, sequencer, output word.
// Depends on fpmm_pkg, fpmm_if and fpmm_fpu.
//
// Load words write one element of the left or right store; an out-of-range
// index gives one error word. A row request runs k times n multiply-adds in
// order on the one shared binary32 unit: each step reads both stores,
// multiplies, then adds the product to the running sum, and each column is
// emitted as one word after its last step. The block takes no new word while
// a row is in progress; one result word is buffered at the output and the
// sequencer waits until it is taken. Store entries never written read as
// arbitrary values. No clearing pass.
module fp32_matrix_multiply (
  input  logic                               clk,
  input  logic                               rst,
  fpmm_if.sink                               in_ch,
  fpmm_if.source                             out_ch,
  input  logic                               cfg_we,
  input  logic [fpmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fpmm_pkg::CFG_W-1:0]         cfg_data
);

  localparam int IW = fpmm_pkg::IDX_W;
  localparam int AW = fpmm_pkg::ADDR_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_ADD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [fpmm_pkg::CFG_W-1:0] rows_m, inner_k, cols_n;
  logic [IW:0] m_eff, k_eff, n_eff;
  logic [2:0] state;
  logic [IW-1:0] row, col, red;
  logic [31:0] sum, prod;
  logic [31:0] left_store [2**AW];
  logic [31:0] right_store [2**AW];
  logic [31:0] left_q, right_q;
  logic [31:0] fa, fb, fres;
  fpmm_pkg::fpu_ctrl_t ctrl;
  fpmm_pkg::fpu_stat_t stat;

  logic [1:0]  in_op;
  logic [IW-1:0] in_row, in_col;
  logic [31:0] in_bits;
  assign {in_op, in_row, in_col, in_bits} = in_ch.data;

  logic        out_valid;
  logic [31:0] out_sum;
  logic [IW-1:0] out_col;
  logic        out_last, out_err;
  assign out_ch.valid = out_valid;
  assign out_ch.data = {out_sum, out_col, out_last, out_err};

  assign m_eff = fpmm_pkg::eff_size(rows_m);
  assign k_eff = fpmm_pkg::eff_size(inner_k);
  assign n_eff = fpmm_pkg::eff_size(cols_n);

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  logic accept;
  assign accept = in_ch.valid && in_ch.ready;

  logic in_err;
  always_comb begin
    case (in_op)
      fpmm_pkg::OP_LOAD_LEFT: in_err = ({1'b0, in_row} >= m_eff) || ({1'b0, in_col} >= k_eff);
      fpmm_pkg::OP_LOAD_RIGHT: in_err = ({1'b0, in_row} >= k_eff) || ({1'b0, in_col} >= n_eff);
      fpmm_pkg::OP_EMIT_ROW: in_err = {1'b0, in_row} >= m_eff;
      default: in_err = 1'b0;
    endcase
  end

  // stores: one write port, one registered read each
  always_ff @(posedge clk) begin
    if (accept && !in_err && in_op == fpmm_pkg::OP_LOAD_LEFT)
      left_store[{in_row, in_col}] <= in_bits;
    if (accept && !in_err && in_op == fpmm_pkg::OP_LOAD_RIGHT)
      right_store[{in_row, in_col}] <= in_bits;
    left_q <= left_store[{row, red}];
    right_q <= right_store[{red, col}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_m <= 7'd1; inner_k <= 7'd1; cols_n <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        fpmm_pkg::REG_ROWS_M: rows_m <= cfg_data;
        fpmm_pkg::REG_INNER_K: inner_k <= cfg_data;
        fpmm_pkg::REG_COLS_N: cols_n <= cfg_data;
        default: ;
      endcase
    end
  end

  logic last_red, last_col;
  assign last_red = {1'b0, red} == k_eff - 1'b1;
  assign last_col = {1'b0, col} == n_eff - 1'b1;

  always_comb begin
    ctrl.start_mul = 1'b0;
    ctrl.start_add = 1'b0;
    fa = left_q;
    fb = right_q;
    if (state == S_MUL && !stat.busy && !stat.done) ctrl.start_mul = 1'b1;
    if (state == S_ADD && !stat.busy && !stat.done) begin
      ctrl.start_add = 1'b1;
      fa = sum;
      fb = prod;
    end
  end

  logic issued;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      issued <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_err) begin
              out_valid <= 1'b1;
              out_sum <= '0; out_col <= '0; out_last <= 1'b0; out_err <= 1'b1;
            end else if (in_op == fpmm_pkg::OP_EMIT_ROW) begin
              row <= in_row; col <= '0; red <= '0; sum <= '0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // address settles, data registered next edge
          state <= S_WAIT;
        end
        S_WAIT: state <= S_MUL;
        S_MUL: begin
          if (stat.done) begin
            prod <= fres;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          if (stat.done) begin
            if (last_red) begin
              sum <= fres;
              state <= S_EMIT;
            end else begin
              sum <= fres;
              red <= red + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_sum <= sum; out_col <= col; out_last <= last_col; out_err <= 1'b0;
            if (last_col) begin
              state <= S_IDLE;
            end else begin
              col <= col + 1'b1; red <= '0; sum <= '0;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      issued <= ctrl.start_mul | ctrl.start_add;
    end
  end

  fpmm_fpu u_fpu (
    .clk(clk), .rst(rst), .ctrl(ctrl), .a(fa), .b(fb), .stat(stat), .result(fres)
  );

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_IDLE) else $error("ready while busy");
  a_issue_busy: assert property (@(posedge clk) disable iff (rst)
    issued |-> stat.busy) else $error("unit did not start");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |=> out_valid && $stable(out_sum)) else $error("word lost");
`endif

endmodule
